// ----- src/wsh_pkg.sv -----
package wsh_pkg;

  localparam logic [63:0] HASH_SEED = 64'h8422_2325_CBF2_9CE4;
  localparam logic [63:0] MIX_MUL   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] ROUND_ADD = 64'h0000_0000_52DC_E729;
  localparam logic [63:0] FIN_MUL_A = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] FIN_MUL_B = 64'hC4CE_B9FE_1A85_EC53;
  localparam int unsigned FIN_SHIFT = 33;

  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_X1,
    ST_MUL_X2,
    ST_POST,
    ST_FIN_PRE
  } state_t;

  typedef enum logic [2:0] {
    PH_MIX1,
    PH_MIX2,
    PH_ROUND,
    PH_FIN_A,
    PH_FIN_B
  } phase_t;

  typedef enum logic [1:0] {
    MS_NONE,
    MS_LO,
    MS_X1,
    MS_X2
  } mul_step_t;

  typedef enum logic [1:0] {
    MC_MIX,
    MC_FIN_A,
    MC_FIN_B
  } mul_const_t;

  typedef enum logic [2:0] {
    PO_NONE,
    PO_ROT31,
    PO_XOR_ROT27,
    PO_XOR_ACC,
    PO_ACC_ADD,
    PO_FIN_PRE,
    PO_FIN_MID,
    PO_FIN_OUT
  } post_op_t;

  typedef struct packed {
    logic       load;
    logic [3:0] load_bytes;
    mul_step_t  mul_step;
    mul_const_t mul_const;
    post_op_t   post_op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  // Bytes that a word contributes: a word that is not the last one always counts as full.
  function automatic logic [3:0] eff_bytes(input logic [3:0] count, input logic last);
    logic [3:0] res;
    if (!last || count > WORD_BYTES) begin
      res = WORD_BYTES;
    end else begin
      res = count;
    end
    return res;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] bytes);
    logic [63:0] mask;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < bytes) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

// ----- src/wsh_if.sv -----
interface wsh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last,
                output ready);
endinterface

interface wsh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

// ----- src/wsh_ctrl.sv -----
module wsh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [3:0]      in_byte_count,
  input  logic            in_last,
  input  wsh_pkg::stat_t  stat,
  output logic            in_ready,
  output wsh_pkg::cmd_t   cmd
);

  wsh_pkg::state_t state_r, state_nxt;
  wsh_pkg::phase_t phase_r, phase_nxt;
  logic            last_r, last_nxt;
  logic            full_r, full_nxt;
  logic [3:0]      eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsh_pkg::ST_IDLE;
      phase_r <= wsh_pkg::PH_MIX1;
      last_r  <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      last_r  <= last_nxt;
      full_r  <= full_nxt;
    end
  end

  assign eff = wsh_pkg::eff_bytes(in_byte_count, in_last);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    last_nxt       = last_r;
    full_nxt       = full_r;
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.load_bytes = eff;
    cmd.mul_step   = wsh_pkg::MS_NONE;
    cmd.post_op    = wsh_pkg::PO_NONE;

    case (phase_r)
      wsh_pkg::PH_FIN_A: cmd.mul_const = wsh_pkg::MC_FIN_A;
      wsh_pkg::PH_FIN_B: cmd.mul_const = wsh_pkg::MC_FIN_B;
      default:           cmd.mul_const = wsh_pkg::MC_MIX;
    endcase

    case (state_r)
      wsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          last_nxt = in_last;
          full_nxt = (eff == wsh_pkg::WORD_BYTES);
          // An empty last word goes straight to the finalizer.
          if (eff == 4'd0) begin
            state_nxt = wsh_pkg::ST_FIN_PRE;
          end else begin
            phase_nxt = wsh_pkg::PH_MIX1;
            state_nxt = wsh_pkg::ST_MUL_LO;
          end
        end
      end
      wsh_pkg::ST_MUL_LO: begin
        cmd.mul_step = wsh_pkg::MS_LO;
        state_nxt    = wsh_pkg::ST_MUL_X1;
      end
      wsh_pkg::ST_MUL_X1: begin
        cmd.mul_step = wsh_pkg::MS_X1;
        state_nxt    = wsh_pkg::ST_MUL_X2;
      end
      wsh_pkg::ST_MUL_X2: begin
        cmd.mul_step = wsh_pkg::MS_X2;
        state_nxt    = wsh_pkg::ST_POST;
      end
      wsh_pkg::ST_POST: begin
        case (phase_r)
          wsh_pkg::PH_MIX1: begin
            cmd.post_op = wsh_pkg::PO_ROT31;
            phase_nxt   = wsh_pkg::PH_MIX2;
            state_nxt   = wsh_pkg::ST_MUL_LO;
          end
          wsh_pkg::PH_MIX2: begin
            if (full_r) begin
              cmd.post_op = wsh_pkg::PO_XOR_ROT27;
              phase_nxt   = wsh_pkg::PH_ROUND;
              state_nxt   = wsh_pkg::ST_MUL_LO;
            end else begin
              // A short word is only a last word and gets no accumulator round.
              cmd.post_op = wsh_pkg::PO_XOR_ACC;
              state_nxt   = wsh_pkg::ST_FIN_PRE;
            end
          end
          wsh_pkg::PH_ROUND: begin
            cmd.post_op = wsh_pkg::PO_ACC_ADD;
            state_nxt   = last_r ? wsh_pkg::ST_FIN_PRE : wsh_pkg::ST_IDLE;
          end
          wsh_pkg::PH_FIN_A: begin
            cmd.post_op = wsh_pkg::PO_FIN_MID;
            phase_nxt   = wsh_pkg::PH_FIN_B;
            state_nxt   = wsh_pkg::ST_MUL_LO;
          end
          wsh_pkg::PH_FIN_B: begin
            // Hold the finished product until the output register is free.
            if (!stat.out_busy) begin
              cmd.post_op = wsh_pkg::PO_FIN_OUT;
              state_nxt   = wsh_pkg::ST_IDLE;
            end
          end
          default: begin
            state_nxt = wsh_pkg::ST_IDLE;
          end
        endcase
      end
      wsh_pkg::ST_FIN_PRE: begin
        cmd.post_op = wsh_pkg::PO_FIN_PRE;
        phase_nxt   = wsh_pkg::PH_FIN_A;
        state_nxt   = wsh_pkg::ST_MUL_LO;
      end
      default: begin
        state_nxt = wsh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/wsh_dp.sv -----
module wsh_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  wsh_pkg::cmd_t  cmd,
  input  logic [63:0]    in_data_word,
  input  logic           out_ready,
  output wsh_pkg::stat_t stat,
  output logic           out_valid,
  output logic [63:0]    out_hash_value
);

  logic [63:0] acc_r, acc_nxt;
  logic [63:0] tot_r, tot_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [63:0] mul_const;
  logic [31:0] mult_a, mult_b;
  logic [63:0] mp;
  logic [63:0] mix_t;
  logic [63:0] fin_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= wsh_pkg::HASH_SEED;
      tot_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      tot_r       <= tot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    prod_r <= prod_nxt;
    hash_r <= hash_nxt;
  end

  always_comb begin
    case (cmd.mul_const)
      wsh_pkg::MC_FIN_A: mul_const = wsh_pkg::FIN_MUL_A;
      wsh_pkg::MC_FIN_B: mul_const = wsh_pkg::FIN_MUL_B;
      default:           mul_const = wsh_pkg::MIX_MUL;
    endcase
  end

  // Low 64 bits of w * const from three 32x32 partial products, one per cycle:
  // lo*lo, then lo*hi and hi*lo added into the upper half.
  assign mult_a = (cmd.mul_step == wsh_pkg::MS_X2) ? w_r[63:32] : w_r[31:0];
  assign mult_b = (cmd.mul_step == wsh_pkg::MS_X1) ? mul_const[63:32] : mul_const[31:0];
  assign mp     = mult_a * mult_b;

  assign mix_t = acc_r ^ prod_r;
  assign fin_h = acc_r ^ tot_r;

  always_comb begin
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    w_nxt         = w_r;
    prod_nxt      = prod_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      w_nxt   = in_data_word & wsh_pkg::byte_mask(cmd.load_bytes);
      tot_nxt = tot_r + 64'(cmd.load_bytes);
    end

    case (cmd.mul_step)
      wsh_pkg::MS_LO: prod_nxt = mp;
      wsh_pkg::MS_X1,
      wsh_pkg::MS_X2: prod_nxt = prod_r + {mp[31:0], 32'd0};
      default:        prod_nxt = prod_r;
    endcase

    case (cmd.post_op)
      wsh_pkg::PO_ROT31:     w_nxt   = {prod_r[32:0], prod_r[63:33]};
      wsh_pkg::PO_XOR_ROT27: w_nxt   = {mix_t[36:0], mix_t[63:37]};
      wsh_pkg::PO_XOR_ACC:   acc_nxt = mix_t;
      wsh_pkg::PO_ACC_ADD:   acc_nxt = prod_r + wsh_pkg::ROUND_ADD;
      wsh_pkg::PO_FIN_PRE:   w_nxt   = fin_h ^ (fin_h >> wsh_pkg::FIN_SHIFT);
      wsh_pkg::PO_FIN_MID:   w_nxt   = prod_r ^ (prod_r >> wsh_pkg::FIN_SHIFT);
      wsh_pkg::PO_FIN_OUT: begin
        hash_nxt      = prod_r ^ (prod_r >> wsh_pkg::FIN_SHIFT);
        out_valid_nxt = 1'b1;
        acc_nxt       = wsh_pkg::HASH_SEED;
        tot_nxt       = 64'd0;
      end
      default: begin
      end
    endcase
  end

  assign stat.out_busy  = out_valid_r && !out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

// ----- src/word_stream_hash64.sv -----
// Streaming 64-bit hash over a message given as little-endian 64-bit words.
// Input channel in_ch: one word per handshake with data_word, byte_count and
// last; byte_count matters only on the last word of a message.
// Result channel out_ch: one hash_value per message, after its last word.
// All 64-bit multiplies run on one shared 32x32 multiplier, three partial
// products per multiply plus a post step that applies the result, so the
// multiplier sets the rate. A word that is not last finishes its round
// before the block returns to idle and accepts the next word.
// A last word is mixed and finalized before its hash shows; a short last
// word skips the accumulator round and an empty one skips all mixing.
// The output register lets the next message start while a hash waits; if a
// second hash finishes while the receiver still stalls, the block holds it
// and accepts no word until the output register frees.
// Reset (rst_n low, synchronous) loads the seed, clears the byte total and
// empties the output register; after each hash the block returns to the seed.
module word_stream_hash64 (
  input  logic       clk,
  input  logic       rst_n,
  wsh_in_if.sink     in_ch,
  wsh_out_if.source  out_ch
);

  wsh_pkg::cmd_t  cmd;
  wsh_pkg::stat_t stat;

  wsh_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_count (in_ch.byte_count),
    .in_last       (in_ch.last),
    .stat          (stat),
    .in_ready      (in_ch.ready),
    .cmd           (cmd)
  );

  wsh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_word   (in_ch.data_word),
    .out_ready      (out_ch.ready),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .out_hash_value (out_ch.hash_value)
  );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

  localparam int WORD_ROT = 31;
  localparam int ACC_ROT = 27;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_WORDS = 900;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_style_t;

  logic clk;
  logic rst_n;

  wsh_in_if  in_ch();
  wsh_out_if out_ch();

  word_stream_hash64 dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [63:0] hash_acc = wsh_pkg::HASH_SEED;
  logic [63:0] byte_total = 64'd0;
  logic [63:0] pending_hashes[$];

  int errors = 0;
  int words_sent = 0;
  int burst_left = 0;
  int max_gap = 0;
  int hold_len = 0;
  int idle_cycles = 0;
  int rx_tick = 0;
  rx_style_t rx_style = RX_ALWAYS;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rotl(input logic [63:0] v, input int s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] mix_word(input logic [63:0] w);
    logic [63:0] t;
    t = w * wsh_pkg::MIX_MUL;
    t = rotl(t, WORD_ROT);
    return t * wsh_pkg::MIX_MUL;
  endfunction

  function automatic logic [63:0] finish_hash(input logic [63:0] h, input logic [63:0] len);
    logic [63:0] t;
    t = h ^ len;
    t = t ^ (t >> wsh_pkg::FIN_SHIFT);
    t = t * wsh_pkg::FIN_MUL_A;
    t = t ^ (t >> wsh_pkg::FIN_SHIFT);
    t = t * wsh_pkg::FIN_MUL_B;
    t = t ^ (t >> wsh_pkg::FIN_SHIFT);
    return t;
  endfunction

  function automatic logic [63:0] acc_round(input logic [63:0] acc, input logic [63:0] w);
    logic [63:0] t;
    t = acc ^ mix_word(w);
    return rotl(t, ACC_ROT) * wsh_pkg::MIX_MUL + wsh_pkg::ROUND_ADD;
  endfunction

  // Updates the running hash for one accepted word and queues the hash of a
  // finished message.
  task automatic absorb_word(input logic [63:0] data, input logic [3:0] cnt,
                             input logic last);
    logic [3:0] n;
    logic [63:0] mask;
    if (!last) begin
      hash_acc = acc_round(hash_acc, data);
      byte_total += 64'd8;
    end else begin
      n = (cnt > 4'd8) ? 4'd8 : cnt;
      if (n == 4'd8) begin
        hash_acc = acc_round(hash_acc, data);
      end else if (n != 4'd0) begin
        mask = (64'd1 << (8 * n)) - 64'd1;
        hash_acc = hash_acc ^ mix_word(data & mask);
      end
      byte_total += 64'(n);
      pending_hashes.push_back(finish_hash(hash_acc, byte_total));
      hash_acc = wsh_pkg::HASH_SEED;
      byte_total = 64'd0;
    end
  endtask

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0: w = 64'd0;
      1: w = ALL_ONES;
      2: w = 64'd1 << $urandom_range(0, 63);
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic last);
    int gap;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data_word <= data;
    in_ch.byte_count <= cnt;
    in_ch.last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_word(data, cnt, last);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_message(input int nwords, input logic [3:0] last_cnt);
    for (int i = 0; i < nwords - 1; i++) begin
      send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    end
    send_word(rand_word(), last_cnt, 1'b1);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    rx_style = RX_ALWAYS;
    max_gap = 0;
    send_word(64'd0, 4'd0, 1'b1);
    send_word(ALL_ONES, 4'd8, 1'b1);
    for (int n = 1; n < 8; n++) begin
      send_word(ALL_ONES, 4'(n), 1'b1);
    end
    // Counts above a full word saturate on the last word.
    send_word(64'h0123_4567_89AB_CDEF, 4'd9, 1'b1);
    send_word(64'hFEDC_BA98_7654_3210, 4'd15, 1'b1);
    // Counts on words that are not last are ignored.
    send_word(ALL_ONES, 4'd3, 1'b0);
    send_word(ALL_ONES, 4'd0, 1'b1);
    send_word(64'd0, 4'd15, 1'b0);
    send_word(64'd0, 4'd8, 1'b1);
    send_word(64'h8000_0000_0000_0001, 4'd0, 1'b0);
    send_word(64'h5555_AAAA_5555_AAAA, 4'd7, 1'b0);
    send_word(64'hAAAA_5555_AAAA_5555, 4'd5, 1'b1);
    wait_drain();
  endtask

  // The receiver holds off long enough for the output register and the
  // finished hash behind it to fill, so the block stops taking words.
  task automatic test_output_backpressure();
    rx_style = RX_ALWAYS;
    max_gap = 0;
    burst_left = 40;
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_message($urandom_range(1, 2), 4'($urandom_range(0, 8)));
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int msgs;
    int nwords;
    logic [3:0] last_cnt;
    msgs = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (msgs % 6 == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
          0: max_gap = 0;
          1: max_gap = 2;
          default: max_gap = 7;
        endcase
      end
      nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      last_cnt = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
      send_message(nwords, last_cnt);
      msgs++;
      if (msgs % 40 == 0) wait_drain();
    end
    wait_drain();
  endtask

  always @(negedge clk) begin
    rx_tick++;
    if (hold_len > 0) begin
      out_ch.ready <= 1'b0;
      hold_len--;
    end else begin
      case (rx_style)
        RX_ALWAYS:   out_ch.ready <= 1'b1;
        RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ch.ready <= ((rx_tick % 7) < 3);
        default:     out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: unexpected hash, expected none, got %h", $time, out_ch.hash_value);
        errors++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_ch.hash_value !== want) begin
          $display("%0t: hash_value expected %h, got %h", $time, want, out_ch.hash_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word or hash accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("word_stream_hash64: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_word = 64'd0;
    in_ch.byte_count = 4'd0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_backpressure();
    test_random_traffic();

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (errors == 0) begin
      $display("word_stream_hash64: match");
    end else begin
      $display("word_stream_hash64: mismatch");
    end
    $finish;
  end

endmodule
